// ===== rtl/amp_pkg.sv =====
// amp_pkg: shared constants and helpers for the angular map probe address block
// no dependencies
package amp_pkg;

  localparam int DefMaxDim   = 8192;
  localparam int DefFracBits = 16;
  localparam int CordicSteps = 24;
  localparam int DimW        = 14;
  localparam int ThrW        = 16;
  localparam int NormW       = 17;   // signed normalized component, +-32768
  localparam int AccW        = 34;   // signed angle accumulator, 2^-32 turn

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    begin
      case (i)
        0: r = 32'd536870912;  1: r = 32'd316933405;  2: r = 32'd167458907;
        3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
        6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
        9: r = 32'd1335086;    10: r = 32'd667544;    11: r = 32'd333772;
        12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41721;
        15: r = 32'd20860;     16: r = 32'd10430;     17: r = 32'd5215;
        18: r = 32'd2607;      19: r = 32'd1303;      20: r = 32'd651;
        21: r = 32'd325;       22: r = 32'd162;       23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/amp_sqrt_pipe.sv =====
// amp_sqrt_pipe: pipelined integer square root, one result bit per stage
// depends on nothing; carries a side payload alongside the radicand
module amp_sqrt_pipe #(
  parameter int InW  = 64,
  parameter int SideW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  input  logic [InW-1:0]       radicand,
  input  logic [SideW-1:0]     side,
  output logic                 root_valid,
  output logic [InW/2-1:0]     root,
  output logic [SideW-1:0]     root_side
);
  localparam int OutW = InW / 2;

  logic [OutW:0]            vld;
  logic [InW-1:0]           rem  [OutW+1];
  logic [OutW-1:0]          res  [OutW+1];
  logic [SideW-1:0]         sd   [OutW+1];

  assign vld[0] = valid;
  assign rem[0] = radicand;
  assign res[0] = '0;
  assign sd[0]  = side;

  // restoring digit-by-digit root, msb first
  for (genvar k = 0; k < OutW; k++) begin : g_stage
    localparam int Sh = 2 * (OutW - 1 - k);
    logic [InW+1:0] trial;
    logic [InW+1:0] rem_ext;
    always_comb begin
      trial   = ({2'b0, {(InW-OutW){1'b0}}, res[k]} << (Sh + 2)) |
                ({{(InW+1){1'b0}}, 1'b1} << Sh);
      rem_ext = {2'b0, rem[k]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      sd[k+1] <= sd[k];
      if (rem_ext >= trial) begin
        rem[k+1] <= InW'(rem_ext - trial);
        res[k+1] <= {res[k][OutW-2:0], 1'b1};
      end else begin
        rem[k+1] <= rem[k];
        res[k+1] <= {res[k][OutW-2:0], 1'b0};
      end
    end
  end

  assign root_valid = vld[OutW];
  assign root       = res[OutW];
  assign root_side  = sd[OutW];
endmodule

// ===== rtl/amp_div_pipe.sv =====
// amp_div_pipe: pipelined unsigned restoring divider, one quotient bit per stage
// depends on nothing; carries a side payload alongside the operands
module amp_div_pipe #(
  parameter int NumW  = 48,
  parameter int DenW  = 32,
  parameter int SideW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic [NumW-1:0]    num,
  input  logic [DenW-1:0]    den,
  input  logic [SideW-1:0]   side,
  output logic               quo_valid,
  output logic [NumW-1:0]    quo,
  output logic [SideW-1:0]   quo_side
);
  logic [NumW:0]    vld;
  logic [DenW-1:0]  rem [NumW+1];
  logic [NumW-1:0]  q   [NumW+1];
  logic [DenW-1:0]  dn  [NumW+1];
  logic [SideW-1:0] sd  [NumW+1];

  assign vld[0] = valid;
  assign rem[0] = '0;
  assign q[0]   = num;
  assign dn[0]  = den;
  assign sd[0]  = side;

  // q holds remaining dividend bits on the left and quotient bits on the right
  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0] shifted;
    always_comb shifted = {rem[k], q[k][NumW-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      dn[k+1] <= dn[k];
      sd[k+1] <= sd[k];
      if (shifted >= {1'b0, dn[k]}) begin
        rem[k+1] <= DenW'(shifted - {1'b0, dn[k]});
        q[k+1]   <= {q[k][NumW-2:0], 1'b1};
      end else begin
        rem[k+1] <= shifted[DenW-1:0];
        q[k+1]   <= {q[k][NumW-2:0], 1'b0};
      end
    end
  end

  assign quo_valid = vld[NumW];
  assign quo       = q[NumW];
  assign quo_side  = sd[NumW];
endmodule

// ===== rtl/amp_cordic_pipe.sv =====
// amp_cordic_pipe: unrolled vectoring cordic, one rotation per register stage
// depends on amp_pkg for the arctangent table
module amp_cordic_pipe
  import amp_pkg::*;
#(
  parameter int SideW = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  input  logic signed [36:0]      cx_in,
  input  logic signed [36:0]      cy_in,
  input  logic signed [AccW-1:0]  acc_in,
  input  logic [SideW-1:0]        side,
  output logic                    ang_valid,
  output logic signed [AccW-1:0]  ang,
  output logic [SideW-1:0]        ang_side
);
  logic [CordicSteps:0]    vld;
  logic signed [36:0]      cx  [CordicSteps+1];
  logic signed [36:0]      cy  [CordicSteps+1];
  logic signed [AccW-1:0]  acc [CordicSteps+1];
  logic [SideW-1:0]        sd  [CordicSteps+1];

  assign vld[0] = valid;
  assign cx[0]  = cx_in;
  assign cy[0]  = cy_in;
  assign acc[0] = acc_in;
  assign sd[0]  = side;

  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    localparam logic signed [AccW-1:0] Step = AccW'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      sd[i+1] <= sd[i];
      if (!cy[i][36]) begin
        cx[i+1]  <= cx[i] + (cy[i] >>> i);
        cy[i+1]  <= cy[i] - (cx[i] >>> i);
        acc[i+1] <= acc[i] + Step;
      end else begin
        cx[i+1]  <= cx[i] - (cy[i] >>> i);
        cy[i+1]  <= cy[i] + (cx[i] >>> i);
        acc[i+1] <= acc[i] - Step;
      end
    end
  end

  assign ang_valid = vld[CordicSteps];
  assign ang       = acc[CordicSteps];
  assign ang_side  = sd[CordicSteps];
endmodule

// ===== rtl/angular_map_probe_address.sv =====
// angular_map_probe_address: top level, direction to angular map pixel address
// depends on amp_pkg, amp_sqrt_pipe, amp_div_pipe, amp_cordic_pipe
//
// Accepts one direction per clock whenever busy is low; busy is tied low, so
// start is taken every cycle. Each transaction returns exactly one result,
// marked by done for one cycle. The pipeline is built from two square-root
// pipelines (32 and 17 stages, one bit per stage), a 46-stage divider for the
// normalization, a 24-stage cordic, a 65-stage divider for the coordinates and
// ten single register stages. Results leave in input order and the receiver
// cannot stall them.
// Image size registers must only change while no transaction is in flight.
module angular_map_probe_address
  import amp_pkg::*;
#(
  parameter int MaxDim   = DefMaxDim,
  parameter int FracBits = DefFracBits
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output logic [12:0]         pixel_col,
  output logic [12:0]         pixel_row,
  output logic [25:0]         pixel_index,
  output logic                invalid_dir
);
  localparam int DimCW = $clog2(MaxDim + 1);

  logic [DimW-1:0] image_width, image_height;
  logic [ThrW-1:0] zero_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= DimW'(1024);
      image_height   <= DimW'(1024);
      zero_threshold <= ThrW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width    <= cfg_data[DimW-1:0];
        REG_HEIGHT: image_height   <= cfg_data[DimW-1:0];
        REG_THRESH: zero_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [DimCW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimCW-1:0] r;
    begin
      if (v == '0) r = DimCW'(1);
      else if (32'(v) > MaxDim) r = DimCW'(MaxDim);
      else r = DimCW'(v);
      return r;
    end
  endfunction

  logic [DimCW-1:0] w, h;
  always_comb begin
    w = clamp_dim(image_width);
    h = clamp_dim(image_height);
  end

  assign busy = 1'b0;

  // stage 1: squares
  logic        v1;
  logic signed [15:0] x1, y1, z1;
  logic [33:0] s1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    x1 <= dir_x; y1 <= dir_y; z1 <= dir_z;
    s1 <= 34'($signed(dir_x) * $signed(dir_x)) + 34'($signed(dir_y) * $signed(dir_y))
        + 34'($signed(dir_z) * $signed(dir_z));
  end

  // q = isqrt(s << 30)
  logic        v2;
  logic [31:0] q2;
  logic [47:0] side2;
  amp_sqrt_pipe #(.InW(64), .SideW(48)) u_norm_sqrt (
    .clk, .rst, .valid(v1), .radicand({s1[33:0], 30'b0}),
    .side({x1, y1, z1}), .root_valid(v2), .root(q2), .root_side(side2)
  );

  // three lanes of normalization division; lane x carries the shared payload
  logic [45:0] mx, my, mz;
  always_comb begin
    mx = {(side2[47] ? 16'(-side2[47:32]) : side2[47:32]), 30'b0};
    my = {(side2[31] ? 16'(-side2[31:16]) : side2[31:16]), 30'b0};
    mz = {(side2[15] ? 16'(-side2[15:0])  : side2[15:0]),  30'b0};
  end
  logic        v3, v3y, v3z;
  logic [45:0] qx, qy, qz;
  logic [3:0]  sg3, sgy_u, sgz_u;
  amp_div_pipe #(.NumW(46), .DenW(32), .SideW(4)) u_div_x (
    .clk, .rst, .valid(v2), .num(mx), .den(q2 == '0 ? 32'd1 : q2),
    .side({q2 == '0, side2[47], side2[31], side2[15]}),
    .quo_valid(v3), .quo(qx), .quo_side(sg3)
  );
  amp_div_pipe #(.NumW(46), .DenW(32), .SideW(4)) u_div_y (
    .clk, .rst, .valid(v2), .num(my), .den(q2 == '0 ? 32'd1 : q2), .side('0),
    .quo_valid(v3y), .quo(qy), .quo_side(sgy_u)
  );
  amp_div_pipe #(.NumW(46), .DenW(32), .SideW(4)) u_div_z (
    .clk, .rst, .valid(v2), .num(mz), .den(q2 == '0 ? 32'd1 : q2), .side('0),
    .quo_valid(v3z), .quo(qz), .quo_side(sgz_u)
  );

  function automatic logic signed [NormW-1:0] sat_norm(input logic [45:0] m,
                                                        input logic neg);
    logic [NormW-1:0] r;
    begin
      r = (m > 46'd32768) ? NormW'(32768) : m[NormW-1:0];
      return neg ? -$signed(r) : $signed(r);
    end
  endfunction

  logic        v4, zero4;
  logic signed [NormW-1:0] nx4, ny4, nz4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    zero4 <= sg3[3];
    nx4 <= sat_norm(qx, sg3[2]);
    ny4 <= sat_norm(qy, sg3[1]);
    nz4 <= sat_norm(qz, sg3[0]);
  end

  // planar length squared times four
  logic        v5, zero5;
  logic signed [NormW-1:0] nx5, ny5, nz5;
  logic [33:0] p5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    zero5 <= zero4; nx5 <= nx4; ny5 <= ny4; nz5 <= nz4;
    p5 <= {34'(nx4 * nx4) + 34'(ny4 * ny4)} << 2;
  end

  logic        v6;
  logic [16:0] d6;
  logic [51:0] side6;
  amp_sqrt_pipe #(.InW(34), .SideW(52)) u_plan_sqrt (
    .clk, .rst, .valid(v5), .radicand(p5),
    .side({zero5, nx5, ny5, nz5}), .root_valid(v6), .root(d6), .root_side(side6)
  );

  // cordic set-up: atan2(d, 2*nz), pre-rotate when nz is negative
  logic        v7;
  logic signed [36:0] cx7, cy7;
  logic signed [AccW-1:0] acc7;
  logic [68:0] side7;
  logic signed [NormW-1:0] nz6;
  logic signed [36:0] cxa, cya;
  always_comb begin
    nz6 = side6[16:0];
    cxa = 37'(nz6) <<< 15;
    cya = 37'($signed({1'b0, d6})) <<< 14;
  end
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    side7 <= {side6[51:17], d6, nz6};
    if (cxa < 0) begin
      cx7 <= cya; cy7 <= -cxa; acc7 <= AccW'(1) <<< 30;
    end else begin
      cx7 <= cxa; cy7 <= cya; acc7 <= '0;
    end
  end

  logic        v8;
  logic signed [AccW-1:0] acc8;
  logic [68:0] side8;
  amp_cordic_pipe #(.SideW(69)) u_cordic (
    .clk, .rst, .valid(v7), .cx_in(cx7), .cy_in(cy7), .acc_in(acc7),
    .side(side7), .ang_valid(v8), .ang(acc8), .ang_side(side8)
  );

  // clamp and round angle to FracBits turn
  localparam int AW = FracBits + 2;
  logic        v9, zero9, small9;
  logic signed [NormW-1:0] nx9, ny9;
  logic [16:0] d9;
  logic [AW-1:0] a9;
  logic signed [AccW-1:0] accc;
  always_comb begin
    accc = acc8;
    if (accc < 0) accc = '0;
    if (accc > (AccW'(1) <<< 31)) accc = AccW'(1) <<< 31;
    accc = accc + (AccW'(1) <<< (31 - FracBits));
  end
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else v9 <= v8;
    zero9  <= side8[68];
    nx9    <= side8[67:51];
    ny9    <= side8[50:34];
    d9     <= side8[33:17];
    small9 <= 32'(side8[33:17]) <= 32'(zero_threshold);
    a9     <= AW'(accc >>> (32 - FracBits));
  end

  // products a*n (registered), then numerators
  logic        v10, zero10, small10;
  logic signed [AW+NormW:0] anx10, any10;
  logic [16:0] d10;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else v10 <= v9;
    zero10 <= zero9; small10 <= small9; d10 <= d9;
    anx10 <= $signed({1'b0, a9}) * nx9;
    any10 <= -($signed({1'b0, a9}) * ny9);
  end

  localparam int NW = DimCW + FracBits + 20;
  logic        v11, zero11, small11;
  logic signed [NW-1:0] numx11, numy11, dx11, dy11;
  logic [16:0] d11;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else v11 <= v10;
    zero11 <= zero10; small11 <= small10; d11 <= d10;
    dx11 <= NW'(($signed({1'b0, d10}) <<< FracBits) + (NW'(anx10) <<< 2));
    dy11 <= NW'(($signed({1'b0, d10}) <<< FracBits) + (NW'(any10) <<< 2));
  end
  localparam int PW = NW + DimCW + 1;
  logic        v12, zero12, small12;
  logic signed [PW-1:0] numx12, numy12;
  logic [16:0] d12;
  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else v12 <= v11;
    zero12 <= zero11; small12 <= small11; d12 <= d11;
    numx12 <= PW'(dx11) * $signed({1'b0, w});
    numy12 <= PW'(dy11) * $signed({1'b0, h});
  end

  localparam int DW = FracBits + 18;
  logic [DW-1:0] den12;
  assign den12 = (d12 == '0) ? DW'(1) : DW'(d12) << (FracBits + 1);

  logic        v13, v13y;
  logic [PW-1:0] cq, rq;
  logic [3:0]  s13, s13y;
  amp_div_pipe #(.NumW(PW), .DenW(DW), .SideW(4)) u_div_col (
    .clk, .rst, .valid(v12), .num(numx12[PW-1] ? '0 : numx12), .den(den12),
    .side({zero12, small12, numx12[PW-1], numy12[PW-1]}),
    .quo_valid(v13), .quo(cq), .quo_side(s13)
  );
  amp_div_pipe #(.NumW(PW), .DenW(DW), .SideW(4)) u_div_row (
    .clk, .rst, .valid(v12), .num(numy12[PW-1] ? '0 : numy12), .den(den12),
    .side('0), .quo_valid(v13y), .quo(rq), .quo_side(s13y)
  );

  // saturate and pick special cases
  logic        v14, zero14;
  logic [DimCW-1:0] col14, row14;
  always_ff @(posedge clk) begin
    if (rst) v14 <= 1'b0;
    else v14 <= v13;
    zero14 <= s13[3];
    if (s13[3]) begin
      col14 <= '0; row14 <= '0;
    end else if (s13[2]) begin
      col14 <= w >> 1; row14 <= h >> 1;
    end else begin
      col14 <= s13[1] ? '0 : (cq >= PW'(w) ? w - 1'b1 : DimCW'(cq));
      row14 <= s13[0] ? '0 : (rq >= PW'(h) ? h - 1'b1 : DimCW'(rq));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v14;
    invalid_dir <= zero14;
    pixel_col   <= 13'(col14);
    pixel_row   <= 13'(row14);
    pixel_index <= 26'(32'(row14) * 32'(w) + 32'(col14));
  end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for angular_map_probe_address
// depends on amp_pkg and the rtl top; holds its own fixed-point predictor of the pixel address
module tb_top;
  import amp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] col;
    logic [12:0] row;
    logic [25:0] index;
    logic        invalid;
  } pixel_t;

  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 typed;
    pixel_t             px;
  } dir_row_t;

  localparam longint WatchdogCycles = 400000;

  logic clk, rst, start, busy, cfg_we, done, invalid_dir;
  logic signed [15:0] dir_x, dir_y, dir_z;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic [12:0] pixel_col, pixel_row;
  logic [25:0] pixel_index;

  angular_map_probe_address uut (.*);

  longint unsigned width_reg, height_reg, thresh_reg;
  pixel_t pending_pixels[$];
  int mismatches, sender_idle_pct;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint normalize(longint c, longint unsigned q);
    longint unsigned mag;
    longint r;
    mag = longint'(c < 0 ? -c : c) << 30;
    r = longint'(mag / q);
    if (r > 32768) r = 32768;
    return c < 0 ? -r : r;
  endfunction

  function automatic longint unsigned fit_dim(longint unsigned v);
    if (v == 0) return 1;
    if (v > DefMaxDim) return DefMaxDim;
    return v;
  endfunction

  function automatic longint unsigned pixel_coord(longint unsigned dim, longint a, longint n,
                                                  longint d16);
    longint num, den;
    longint unsigned c;
    num = longint'(dim) * (64'sd1 << DefFracBits) * d16 + 4 * longint'(dim) * a * n;
    den = (64'sd1 << (DefFracBits + 1)) * d16;
    if (num < 0) return 0;
    c = longint'(num / den);
    if (c > dim - 1) c = dim - 1;
    return c;
  endfunction

  function automatic pixel_t predict_pixel(longint x, longint y, longint z);
    pixel_t p;
    longint unsigned w, h, s, q, col, row;
    longint nx, ny, nz, d16, cx, cy, acc, a, t, dx, dy;
    w = fit_dim(width_reg);
    h = fit_dim(height_reg);
    s = x * x + y * y + z * z;
    p = '0;
    if (s == 0) begin
      p.invalid = 1'b1;
      return p;
    end
    q = isqrt(s << 30);
    nx = normalize(x, q);
    ny = normalize(y, q);
    nz = normalize(z, q);
    d16 = longint'(isqrt((nx * nx + ny * ny) * 4));
    if (d16 <= longint'(thresh_reg)) begin
      col = w / 2;
      row = h / 2;
    end else begin
      cx = nz * 2 * 16384;
      cy = d16 * 16384;
      acc = 0;
      // rotate a left-half vector by a quarter turn so cordic converges
      if (cx < 0) begin
        t = cx;
        cx = cy;
        cy = -t;
        acc = 64'sd1 << 30;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx;
          cy -= dy;
          acc += longint'(atan_turn(i));
        end else begin
          cx -= dx;
          cy += dy;
          acc -= longint'(atan_turn(i));
        end
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 << 31)) acc = 64'sd1 << 31;
      a = (acc + (64'sd1 << (31 - DefFracBits))) >>> (32 - DefFracBits);
      col = pixel_coord(w, a, nx, d16);
      row = pixel_coord(h, a, -ny, d16);
    end
    p.col = col[12:0];
    p.row = row[12:0];
    p.index = 26'(row * w + col);
    return p;
  endfunction

  // results sampled mid-cycle so the order of edge events never matters
  always @(negedge clk) begin
    pixel_t got, want;
    cycles++;
    if (!rst && done) begin
      got = '{pixel_col, pixel_row, pixel_index, invalid_dir};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch expected %p actual %p", want, got);
        end
      end
    end
    if (cycles > WatchdogCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_WIDTH) width_reg = val & 16'h3FFF;
    else if (idx == REG_HEIGHT) height_reg = val & 16'h3FFF;
    else if (idx == REG_THRESH) thresh_reg = val;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // drive one transaction; the typed row wins over the predictor when given
  task automatic send_dir(dir_row_t r);
    bit taken;
    start <= 1'b1;
    dir_x <= r.x;
    dir_y <= r.y;
    dir_z <= r.z;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    pending_pixels.insert(pending_pixels.size(),
                          r.typed ? r.px : predict_pixel(r.x, r.y, r.z));
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  function automatic dir_row_t random_dir();
    dir_row_t r;
    r.typed = 0;
    case ($urandom_range(9))
      0: begin r.x = 0; r.y = 0; r.z = 0; end
      1, 2: begin
        r.x = $signed(16'($urandom_range(6))) - 16'sd3;
        r.y = $signed(16'($urandom_range(6))) - 16'sd3;
        r.z = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
      end
      3: begin
        r.x = $signed(16'($urandom_range(64))) - 16'sd32;
        r.y = $signed(16'($urandom_range(64))) - 16'sd32;
        r.z = $signed(16'($urandom_range(64))) - 16'sd32;
      end
      default: begin
        r.x = 16'($urandom); r.y = 16'($urandom); r.z = 16'($urandom);
      end
    endcase
    return r;
  endfunction

  dir_row_t directed[$];

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    dir_x = '0;
    dir_y = '0;
    dir_z = '0;
    width_reg = 1024;
    height_reg = 1024;
    thresh_reg = 1;
    mismatches = 0;
    cycles = 0;
    sender_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset configuration
    directed = '{
      '{0, 0, 0, 1, '{0, 0, 0, 1}},
      '{0, 0, 100, 1, '{512, 512, 524800, 0}},
      '{0, 0, -5, 1, '{512, 512, 524800, 0}},
      '{0, 0, -16'sh8000, 1, '{512, 512, 524800, 0}},
      '{32767, 0, 0, 0, '0}, '{-16'sh8000, 0, 0, 0, '0},
      '{0, 32767, 0, 0, '0}, '{0, -16'sh8000, 0, 0, '0},
      '{32767, 32767, 32767, 0, '0},
      '{-16'sh8000, -16'sh8000, -16'sh8000, 0, '0},
      '{1, 0, -16'sh8000, 0, '0}, '{-1, 0, -16'sh8000, 0, '0},
      '{0, 1, -16'sh8000, 0, '0}, '{0, -1, -16'sh8000, 0, '0},
      '{1, 1, 1, 0, '0}, '{-1, 1, -1, 0, '0},
      '{16'sh5555, -16'sh2AAB, 16'sh1234, 0, '0},
      '{-16'sh4000, 16'sh7000, -16'sh7FFF, 0, '0}
    };
    foreach (directed[i]) send_dir(directed[i]);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_WIDTH, 1); write_reg(REG_HEIGHT, 1); write_reg(REG_THRESH, 0);
          write_reg(2'd3, 16'hFFFF);
          sender_idle_pct = 0;
        end
        1: begin
          write_reg(REG_WIDTH, 0); write_reg(REG_HEIGHT, 16'hFFFF);
          write_reg(REG_THRESH, 16'hFFFF);
          sender_idle_pct = 72;
        end
        2: begin
          write_reg(REG_WIDTH, 8192); write_reg(REG_HEIGHT, 8192); write_reg(REG_THRESH, 0);
          sender_idle_pct = 0;
        end
        default: begin
          write_reg(REG_WIDTH, 640); write_reg(REG_HEIGHT, 480); write_reg(REG_THRESH, 100);
          sender_idle_pct = 33;
        end
      endcase
      cfg_we <= 1'b0;
      for (int n = 0; n < 300; n++) send_dir(random_dir());
      drain();
    end

    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
